>>> sv/mtt_pkg.sv
package mtt_pkg;

  // Width of the internal line, column and byte counters
  localparam int unsigned POS_W = 32;
  // Width of every reported position field
  localparam int unsigned OUT_W = 32;

  localparam int unsigned TAB_W = 5;
  localparam logic [TAB_W-1:0] TAB_RESET = 5'd4;

  // Register map (index = byte address / 4)
  localparam logic REG_TAB_WIDTH = 1'b0;

  // Input kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  // Character roles
  localparam logic [2:0] ROLE_MARKUP  = 3'd0;
  localparam logic [2:0] ROLE_NAME    = 3'd1;
  localparam logic [2:0] ROLE_ATTR    = 3'd2;
  localparam logic [2:0] ROLE_TEXT    = 3'd3;
  localparam logic [2:0] ROLE_COMMENT = 3'd4;

  // Token kinds
  localparam logic [1:0] TOK_ELEMENT = 2'd0;
  localparam logic [1:0] TOK_COMMENT = 2'd1;
  localparam logic [1:0] TOK_TEXT    = 2'd2;

  // Characters
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // "!-" name prefix that opens a comment on the next dash, "--" comment closer
  localparam logic [15:0] PREFIX_BANG_DASH = 16'h212D;
  localparam logic [15:0] TAIL_DASH_DASH   = 16'h2D2D;

  // One result transaction
  typedef struct packed {
    logic [7:0]       char_out;
    logic [2:0]       char_role;
    logic             tag_done;
    logic [1:0]       tag_kind;
    logic [OUT_W-1:0] start_line;
    logic [OUT_W-1:0] open_column;
    logic [OUT_W-1:0] open_position;
    logic [OUT_W-1:0] end_line;
    logic [OUT_W-1:0] close_column;
    logic [OUT_W-1:0] close_position;
  } res_t;

  // Saturating add of a small increment to a counter
  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [TAB_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + (POS_W+1)'(b);
    return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
  endfunction

  // Counter value clamped to the reported field width
  function automatic logic [OUT_W-1:0] sat_out(input logic [POS_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'(32'hFFFF_FFFF)) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
  endfunction

  // Decrement that stops at zero
  function automatic logic [POS_W-1:0] dec_floor(input logic [POS_W-1:0] v);
    return (v == '0) ? '0 : v - POS_W'(1);
  endfunction

endpackage

>>> sv/mtt_core.sv
// Tokenizer state and per-byte classification; result is combinational
module mtt_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       kind_i,
  input  logic [7:0]                 char_i,
  input  logic [mtt_pkg::TAB_W-1:0]  tab_width_i,
  output mtt_pkg::res_t              res_o
);

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_NAME    = 3'd1,
    M_ARGS    = 3'd2,
    M_DATA    = 3'd3,
    M_COMMENT = 3'd4
  } mode_e;

  mode_e                     mode_q, mode_d;
  logic [mtt_pkg::POS_W-1:0] line_q, line_d, col_q, col_d, byte_q, byte_d;
  logic [mtt_pkg::POS_W-1:0] oline_q, oline_d, ocol_q, ocol_d, opos_q, opos_d;
  logic [1:0]                nlen_q, nlen_d, clen_q, clen_d;
  logic [15:0]               nprefix_q, nprefix_d, ctail_q, ctail_d;

  logic [mtt_pkg::POS_W-1:0] line_n, col_n, byte_n;
  logic [mtt_pkg::POS_W-1:0] cl_line, cl_col, cl_byte;
  logic                      is_eos;

  // Position counters after this byte
  always_comb begin
    byte_n = mtt_pkg::sat_add(byte_q, mtt_pkg::TAB_W'(1));
    line_n = line_q;
    if (char_i == mtt_pkg::CH_TAB) begin
      col_n = mtt_pkg::sat_add(col_q, tab_width_i);
    end else if (char_i == mtt_pkg::CH_CR) begin
      col_n = '0;
    end else begin
      col_n = mtt_pkg::sat_add(col_q, mtt_pkg::TAB_W'(1));
    end
    if (char_i == mtt_pkg::CH_LF) begin
      col_n  = '0;
      line_n = mtt_pkg::sat_add(line_q, mtt_pkg::TAB_W'(1));
    end
  end

  // Close positions: end of stream reports the counters as they stand
  assign is_eos  = (kind_i == mtt_pkg::KIND_EOS);
  assign cl_line = is_eos ? line_q : line_n;
  assign cl_col  = is_eos ? col_q  : col_n;
  assign cl_byte = is_eos ? byte_q : byte_n;

  // Mode transitions and result
  always_comb begin
    logic emit;
    logic save;
    emit      = 1'b0;
    save      = 1'b0;
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    byte_d    = byte_q;
    oline_d   = oline_q;
    ocol_d    = ocol_q;
    opos_d    = opos_q;
    nlen_d    = nlen_q;
    nprefix_d = nprefix_q;
    clen_d    = clen_q;
    ctail_d   = ctail_q;
    res_o     = '0;
    res_o.char_out = char_i;

    if (accept_i) begin
      if (is_eos) begin
        // flush a pending text run, then restart the stream
        res_o.char_out = '0;
        if (mode_q == M_DATA) begin
          emit = 1'b1;
          res_o.tag_kind = mtt_pkg::TOK_TEXT;
        end
        mode_d    = M_IDLE;
        line_d    = '0;
        col_d     = '0;
        byte_d    = '0;
        oline_d   = '0;
        ocol_d    = '0;
        opos_d    = '0;
        nlen_d    = '0;
        nprefix_d = '0;
        clen_d    = '0;
        ctail_d   = '0;
      end else begin
        line_d = line_n;
        col_d  = col_n;
        byte_d = byte_n;
        unique case (mode_q)
          M_IDLE: begin
            save = 1'b1;
            if (char_i == mtt_pkg::CH_LT) begin
              nlen_d    = '0;
              nprefix_d = '0;
              mode_d    = M_NAME;
            end else begin
              res_o.char_role = mtt_pkg::ROLE_TEXT;
              mode_d          = M_DATA;
            end
          end
          M_NAME: begin
            if (char_i == mtt_pkg::CH_GT) begin
              emit           = 1'b1;
              res_o.tag_kind = mtt_pkg::TOK_ELEMENT;
              mode_d         = M_IDLE;
            end else if (char_i == mtt_pkg::CH_SPACE) begin
              mode_d = M_ARGS;
            end else begin
              res_o.char_role = mtt_pkg::ROLE_NAME;
              if (char_i >= mtt_pkg::CH_UP_A && char_i <= mtt_pkg::CH_UP_Z) begin
                res_o.char_out = char_i + mtt_pkg::CASE_OFS;
              end
              // third name byte completing "!--" opens a comment
              if (nlen_q == 2'd2 && nprefix_q == mtt_pkg::PREFIX_BANG_DASH &&
                  char_i == mtt_pkg::CH_DASH) begin
                ctail_d = '0;
                clen_d  = '0;
                mode_d  = M_COMMENT;
              end else if (nlen_q < 2'd2) begin
                nprefix_d = {nprefix_q[7:0], char_i};
              end
              if (nlen_q != 2'd3) begin
                nlen_d = nlen_q + 2'd1;
              end
            end
          end
          M_ARGS: begin
            if (char_i == mtt_pkg::CH_GT) begin
              emit           = 1'b1;
              res_o.tag_kind = mtt_pkg::TOK_ELEMENT;
              mode_d         = M_IDLE;
            end else begin
              res_o.char_role = mtt_pkg::ROLE_ATTR;
            end
          end
          M_DATA: begin
            if (char_i == mtt_pkg::CH_LT) begin
              emit           = 1'b1;
              res_o.tag_kind = mtt_pkg::TOK_TEXT;
              save           = 1'b1;
              nlen_d         = '0;
              nprefix_d      = '0;
              mode_d         = M_NAME;
            end else begin
              res_o.char_role = mtt_pkg::ROLE_TEXT;
            end
          end
          M_COMMENT: begin
            if (char_i == mtt_pkg::CH_GT && clen_q == 2'd2 &&
                ctail_q == mtt_pkg::TAIL_DASH_DASH) begin
              emit           = 1'b1;
              res_o.tag_kind = mtt_pkg::TOK_COMMENT;
              mode_d         = M_IDLE;
            end else begin
              res_o.char_role = mtt_pkg::ROLE_COMMENT;
              ctail_d         = {ctail_q[7:0], char_i};
              if (clen_q != 2'd2) begin
                clen_d = clen_q + 2'd1;
              end
            end
          end
          default: begin
            mode_d = M_IDLE;
          end
        endcase
      end
    end

    // record uses the open position held before this byte
    if (emit) begin
      res_o.tag_done       = 1'b1;
      res_o.start_line     = mtt_pkg::sat_out(oline_q);
      res_o.open_column    = mtt_pkg::sat_out(ocol_q);
      res_o.open_position  = mtt_pkg::sat_out(opos_q);
      res_o.end_line       = mtt_pkg::sat_out(cl_line);
      res_o.close_column   = mtt_pkg::sat_out(mtt_pkg::dec_floor(cl_col));
      res_o.close_position = mtt_pkg::sat_out(mtt_pkg::dec_floor(cl_byte));
    end
    if (save) begin
      oline_d = mtt_pkg::sat_add(line_n, mtt_pkg::TAB_W'(1));
      ocol_d  = col_n;
      opos_d  = byte_n;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      line_q    <= '0;
      col_q     <= '0;
      byte_q    <= '0;
      oline_q   <= '0;
      ocol_q    <= '0;
      opos_q    <= '0;
      nlen_q    <= '0;
      nprefix_q <= '0;
      clen_q    <= '0;
      ctail_q   <= '0;
    end else begin
      mode_q    <= mode_d;
      line_q    <= line_d;
      col_q     <= col_d;
      byte_q    <= byte_d;
      oline_q   <= oline_d;
      ocol_q    <= ocol_d;
      opos_q    <= opos_d;
      nlen_q    <= nlen_d;
      nprefix_q <= nprefix_d;
      clen_q    <= clen_d;
      ctail_q   <= ctail_d;
    end
  end

endmodule

>>> sv/mtt_skid.sv
// Output register plus skid stage; upstream ready is registered
module mtt_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mtt_pkg::res_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mtt_pkg::res_t out_data_o
);

  logic          out_valid_q, skid_valid_q;
  mtt_pkg::res_t out_data_q, skid_data_q;
  logic          out_free;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_valid_i;
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_data_q <= in_data_i;
    end
  end

endmodule

>>> sv/markup_tag_tokenizer.sv
// A result is registered in the output stage, or in the skid entry under stall.
// One byte per cycle while s_axis_tready is high; tokenizer state updates on accept.
// A two-entry output stage (register plus skid) keeps s_axis_tready registered.
// Reset: asynchronous, active low; clears mode, counters, open positions, output
// valids, and sets tab_width to 4. An end-of-stream item clears mode, counters
// and open positions, but not the output valids or tab_width.
module markup_tag_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tuser,   // [0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] char_out, [39:8] start_line, [71:40] open_column, [103:72] open_position,
  // [135:104] end_line, [167:136] close_column, [199:168] close_position
  output logic [199:0] m_axis_tdata,
  // [2:0] char_role, [3] tag_done, [5:4] tag_kind
  output logic [5:0]  m_axis_tuser,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [mtt_pkg::TAB_W-1:0] tab_width_q;
  logic                      in_accept;
  mtt_pkg::res_t             res, res_out;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_width_q <= mtt_pkg::TAB_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mtt_pkg::REG_TAB_WIDTH) begin
      tab_width_q <= pwdata[mtt_pkg::TAB_W-1:0];
    end
  end
  assign prdata = (paddr[2] == mtt_pkg::REG_TAB_WIDTH) ? 32'(tab_width_q) : '0;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  mtt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .kind_i      (s_axis_tuser),
    .char_i      (s_axis_tdata),
    .tab_width_i (tab_width_q),
    .res_o       (res)
  );

  mtt_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_out)
  );

  // Pack result fields
  assign m_axis_tdata = {res_out.close_position, res_out.close_column, res_out.end_line,
                         res_out.open_position, res_out.open_column, res_out.start_line,
                         res_out.char_out};
  assign m_axis_tuser = {res_out.tag_kind, res_out.tag_done, res_out.char_role};

  // Input stalls only while a result is held on the master side
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // After every accepted transaction, m_axis_tvalid is high on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

  // Without a record, kind and positions are zero
  a_no_record_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[3]) |-> (m_axis_tdata[199:8] == '0 &&
                                              m_axis_tuser[5:4] == 2'd0))
    else $error("record fields set without tag_done");

  // Name characters leave lowercased
  a_name_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2:0] == mtt_pkg::ROLE_NAME) |->
      !(m_axis_tdata[7:0] >= mtt_pkg::CH_UP_A && m_axis_tdata[7:0] <= mtt_pkg::CH_UP_Z))
    else $error("uppercase name character on output");

endmodule

>>> verif/tb_markup_tag_tokenizer.sv
module tb_markup_tag_tokenizer;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam logic [2:0]  TAB_ADDR       = {mtt_pkg::REG_TAB_WIDTH, 2'b00};

  // Scanner states of the tokenizer
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NAME, SCAN_ARGS, SCAN_DATA, SCAN_COMMENT
  } scan_e;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // [7:0] char_in
  logic         s_axis_tuser;   // [0] kind
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [7:0] char_out, [39:8] start_line, [71:40] open_column, [103:72] open_position,
  // [135:104] end_line, [167:136] close_column, [199:168] close_position
  logic [199:0] m_axis_tdata;
  // [2:0] char_role, [3] tag_done, [5:4] tag_kind
  logic [5:0]   m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  markup_tag_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Shared testbench state
  mtt_pkg::res_t tok_results_q[$];
  int unsigned   err_cnt     = 0;
  int unsigned   items_sent  = 0;
  int unsigned   idle_cycles = 0;
  bit            gaps_on     = 1'b1;
  bit            stall_on    = 1'b1;
  bit            sink_hold   = 1'b0;

  // Tokenizer prediction state
  logic [4:0]  tab_q;
  scan_e       scan_q;
  logic [31:0] line_q, col_q, pos_q;
  logic [31:0] oline_q, ocol_q, opos_q;
  logic [1:0]  name_len_q, cmt_len_q;
  logic [15:0] name_pfx_q, cmt_tail_q;

  function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic clear_scan();
    scan_q     = SCAN_IDLE;
    line_q     = '0;
    col_q      = '0;
    pos_q      = '0;
    oline_q    = '0;
    ocol_q     = '0;
    opos_q     = '0;
    name_len_q = '0;
    name_pfx_q = '0;
    cmt_len_q  = '0;
    cmt_tail_q = '0;
  endtask

  task automatic mark_open();
    oline_q = sat_inc(line_q, 32'd1);
    ocol_q  = col_q;
    opos_q  = pos_q;
  endtask

  // Token record: close column and position are one back, floored at zero
  task automatic close_token(input logic [1:0] kind, inout mtt_pkg::res_t r);
    r.tag_done       = 1'b1;
    r.tag_kind       = kind;
    r.start_line     = oline_q;
    r.open_column    = ocol_q;
    r.open_position  = opos_q;
    r.end_line       = line_q;
    r.close_column   = (col_q == '0) ? '0 : col_q - 32'd1;
    r.close_position = (pos_q == '0) ? '0 : pos_q - 32'd1;
  endtask

  // Predict the result of one input transaction and advance the state
  task automatic tokenize_byte(input logic kind, input logic [7:0] ch,
                               output mtt_pkg::res_t r);
    logic [2:0] role;
    logic [7:0] cout;
    r    = '0;
    role = mtt_pkg::ROLE_MARKUP;
    cout = ch;
    if (kind == mtt_pkg::KIND_EOS) begin
      if (scan_q == SCAN_DATA) close_token(mtt_pkg::TOK_TEXT, r);
      clear_scan();
      return;
    end
    pos_q = sat_inc(pos_q, 32'd1);
    if (ch == mtt_pkg::CH_TAB) col_q = sat_inc(col_q, 32'(tab_q));
    else if (ch == mtt_pkg::CH_CR) col_q = '0;
    else col_q = sat_inc(col_q, 32'd1);
    if (ch == mtt_pkg::CH_LF) begin
      col_q  = '0;
      line_q = sat_inc(line_q, 32'd1);
    end
    case (scan_q)
      SCAN_IDLE: begin
        mark_open();
        if (ch == mtt_pkg::CH_LT) begin
          name_len_q = '0;
          name_pfx_q = '0;
          scan_q     = SCAN_NAME;
        end else begin
          role   = mtt_pkg::ROLE_TEXT;
          scan_q = SCAN_DATA;
        end
      end
      SCAN_NAME: begin
        if (ch != mtt_pkg::CH_SPACE && ch != mtt_pkg::CH_GT) begin
          role = mtt_pkg::ROLE_NAME;
          if (ch >= mtt_pkg::CH_UP_A && ch <= mtt_pkg::CH_UP_Z) cout = ch + mtt_pkg::CASE_OFS;
          if (name_len_q == 2'd2 && name_pfx_q == mtt_pkg::PREFIX_BANG_DASH &&
              ch == mtt_pkg::CH_DASH) begin
            cmt_tail_q = '0;
            cmt_len_q  = '0;
            scan_q     = SCAN_COMMENT;
          end else if (name_len_q < 2'd2) begin
            name_pfx_q = {name_pfx_q[7:0], ch};
          end
          if (name_len_q < 2'd3) name_len_q++;
        end else if (ch == mtt_pkg::CH_GT) begin
          close_token(mtt_pkg::TOK_ELEMENT, r);
          scan_q = SCAN_IDLE;
        end else begin
          scan_q = SCAN_ARGS;
        end
      end
      SCAN_ARGS: begin
        if (ch != mtt_pkg::CH_GT) begin
          role = mtt_pkg::ROLE_ATTR;
        end else begin
          close_token(mtt_pkg::TOK_ELEMENT, r);
          scan_q = SCAN_IDLE;
        end
      end
      SCAN_DATA: begin
        if (ch == mtt_pkg::CH_LT) begin
          close_token(mtt_pkg::TOK_TEXT, r);
          mark_open();
          name_len_q = '0;
          name_pfx_q = '0;
          scan_q     = SCAN_NAME;
        end else begin
          role = mtt_pkg::ROLE_TEXT;
        end
      end
      SCAN_COMMENT: begin
        if (ch == mtt_pkg::CH_GT && cmt_len_q == 2'd2 &&
            cmt_tail_q == mtt_pkg::TAIL_DASH_DASH) begin
          close_token(mtt_pkg::TOK_COMMENT, r);
          scan_q = SCAN_IDLE;
        end else begin
          role       = mtt_pkg::ROLE_COMMENT;
          cmt_tail_q = {cmt_tail_q[7:0], ch};
          if (cmt_len_q < 2'd2) cmt_len_q++;
        end
      end
      default: scan_q = SCAN_IDLE;
    endcase
    r.char_out  = cout;
    r.char_role = role;
  endtask

  // Send one input transaction; waits for the edge that accepts it, then may idle for a gap
  task automatic send_item(input logic kind, input logic [7:0] ch);
    mtt_pkg::res_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    tokenize_byte(kind, ch, r);
    tok_results_q = {tok_results_q, r};
    items_sent++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(mtt_pkg::KIND_CHAR, s[i]);
  endtask

  // Stop the input and wait until every predicted result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tok_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TAB_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tab_q    = data[4:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read back tab_width and compare with the predicted value
  task automatic apb_check_tab();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TAB_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(tab_q)) begin
      $error("tab_width readback mismatch: expected %0h, got %0h", 32'(tab_q), prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_tab_width(input logic [4:0] w);
    drain();
    apb_write({27'($urandom_range(0, 32'h07FF_FFFF)), w});
    @(posedge clk_i);
    apb_check_tab();
  endtask

  // Random name byte: letters of both cases, case-fold edges, or any legal byte
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = mtt_pkg::CH_UP_A + 8'($urandom_range(0, 25));
      1: c = mtt_pkg::CH_UP_A + mtt_pkg::CASE_OFS + 8'($urandom_range(0, 25));
      2: c = ($urandom_range(0, 1) != 0) ? mtt_pkg::CH_UP_A - 8'd1 : mtt_pkg::CH_UP_Z + 8'd1;
      default: begin
        do c = 8'($urandom_range(0, 255));
        while (c == mtt_pkg::CH_SPACE || c == mtt_pkg::CH_GT);
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = mtt_pkg::CH_TAB;
      1: c = mtt_pkg::CH_LF;
      2: c = mtt_pkg::CH_CR;
      3: c = mtt_pkg::CH_SPACE;
      default: begin
        do c = 8'($urandom_range(0, 255)); while (c == mtt_pkg::CH_LT);
      end
    endcase
    return c;
  endfunction

  // One random token: mostly well-formed markup, some noise and stream ends
  task automatic send_token();
    int unsigned pick;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_item(mtt_pkg::KIND_CHAR, mtt_pkg::CH_LT);
      repeat ($urandom_range(0, 5)) send_item(mtt_pkg::KIND_CHAR, name_char());
      if ($urandom_range(0, 1) != 0) begin
        send_item(mtt_pkg::KIND_CHAR, mtt_pkg::CH_SPACE);
        repeat ($urandom_range(0, 6)) begin
          do c = text_char(); while (c == mtt_pkg::CH_GT);
          send_item(mtt_pkg::KIND_CHAR, c);
        end
      end
      if ($urandom_range(0, 9) != 0) send_item(mtt_pkg::KIND_CHAR, mtt_pkg::CH_GT);
    end else if (pick < 55) begin
      send_text("<!--");
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 3))
          0: send_item(mtt_pkg::KIND_CHAR, mtt_pkg::CH_DASH);
          1: send_item(mtt_pkg::KIND_CHAR, mtt_pkg::CH_GT);
          default: send_item(mtt_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
        endcase
      end
      if ($urandom_range(0, 7) != 0) send_text("-->");
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 8)) send_item(mtt_pkg::KIND_CHAR, text_char());
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(mtt_pkg::KIND_CHAR, text_char() & 8'h0F | 8'h08);
      end
    end else if (pick < 92) begin
      send_item(mtt_pkg::KIND_EOS, 8'($urandom_range(0, 255)));
    end else begin
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int unsigned count, input bit allow_idle);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < count) begin
      if (allow_idle && $urandom_range(0, 9) == 0) begin
        gaps_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      send_token();
    end
  endtask

  // Counters, tabs, CR/LF, name lowercasing, empty tags and attributes
  task automatic test_elements_and_text();
    send_text("x\t<AZ@[ q>");
    send_item(mtt_pkg::KIND_CHAR, mtt_pkg::CH_CR);
    send_text("\n<>< >");
  endtask

  // Comment opener, a '>' that does not close, then a proper close
  task automatic test_comments();
    send_text("<!-->-->");
  endtask

  // End of stream: reports a pending text run, drops a tag, resets the counters
  task automatic test_stream_end();
    send_item(mtt_pkg::KIND_CHAR, 8'h00);
    send_item(mtt_pkg::KIND_CHAR, 8'hFF);
    send_item(mtt_pkg::KIND_EOS, 8'hA5);
    send_text("<ab");
    send_item(mtt_pkg::KIND_EOS, 8'h5A);
    send_item(mtt_pkg::KIND_EOS, 8'h00);
  endtask

  task automatic test_tab_widths();
    run_random(100, 1'b1);
    set_tab_width(5'd1);
    run_random(120, 1'b1);
    set_tab_width(5'd16);
    run_random(120, 1'b1);
    set_tab_width(5'd0);
    run_random(120, 1'b1);
    set_tab_width(5'd31);
    run_random(120, 1'b1);
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    sink_hold = 1'b1;
    run_random(40, 1'b0);
  endtask

  task automatic test_random_no_idle();
    set_tab_width(5'($urandom_range(2, 15)));
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    run_random(200, 1'b0);
  endtask

  // Receiver ready with random stall bursts and one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : result_check
    mtt_pkg::res_t got;
    mtt_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.char_out       = m_axis_tdata[7:0];
      got.start_line     = m_axis_tdata[39:8];
      got.open_column    = m_axis_tdata[71:40];
      got.open_position  = m_axis_tdata[103:72];
      got.end_line       = m_axis_tdata[135:104];
      got.close_column   = m_axis_tdata[167:136];
      got.close_position = m_axis_tdata[199:168];
      got.char_role      = m_axis_tuser[2:0];
      got.tag_done       = m_axis_tuser[3];
      got.tag_kind       = m_axis_tuser[5:4];
      if (tok_results_q.size() == 0) begin
        $error("result transaction with no prediction pending");
        err_cnt++;
      end else begin
        want = tok_results_q.pop_front();
        check_field("char_out", 32'(want.char_out), 32'(got.char_out));
        check_field("char_role", 32'(want.char_role), 32'(got.char_role));
        check_field("tag_done", 32'(want.tag_done), 32'(got.tag_done));
        check_field("tag_kind", 32'(want.tag_kind), 32'(got.tag_kind));
        check_field("open_line", want.start_line, got.start_line);
        check_field("open_column", want.open_column, got.open_column);
        check_field("open_position", want.open_position, got.open_position);
        check_field("close_line", want.end_line, got.end_line);
        check_field("close_column", want.close_column, got.close_column);
        check_field("close_position", want.close_position, got.close_position);
      end
    end
  end

  // Watchdog on cycles without any input, output or configuration transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL markup_tag_tokenizer");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = mtt_pkg::KIND_CHAR;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tab_q         = mtt_pkg::TAB_RESET;
    clear_scan();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_check_tab();
    test_elements_and_text();
    test_comments();
    test_stream_end();
    test_tab_widths();
    test_backpressure();
    test_random_no_idle();

    drain();
    if (err_cnt == 0) begin
      $display("PASS markup_tag_tokenizer");
    end else begin
      $display("FAIL markup_tag_tokenizer");
    end
    $finish;
  end

endmodule
